// ===== design/lcasr_pkg.sv =====
// Shared constants and types for the load-cell converter serial reader.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package lcasr_pkg;

    // Converter and sequence constants.
    localparam int ADC_BITS         = 24;
    localparam int MAX_AVERAGES     = 255;
    localparam int POWER_DOWN_TICKS = 60;

    // Field and register widths.
    localparam int OP_W       = 2;
    localparam int CNT_W      = 8;
    localparam int GAIN_W     = 2;
    localparam int RAW_W      = 24;
    localparam int DATA_W     = 32;
    localparam int HALF_W     = 8;
    localparam int TMO_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Derived widths: pulse counter holds ADC_BITS plus up to three gain pulses,
    // and the sum holds MAX_AVERAGES signed 32-bit samples.
    localparam int PULSE_W   = $clog2(ADC_BITS + 4);
    localparam int SUM_W     = DATA_W + $clog2(MAX_AVERAGES + 1);
    localparam int DIV_CNT_W = $clog2(SUM_W);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_TICK       = 2'd0;
    localparam logic [OP_W-1:0] OP_INIT       = 2'd1;
    localparam logic [OP_W-1:0] OP_READ       = 2'd2;
    localparam logic [OP_W-1:0] OP_POWER_DOWN = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PULSES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_OFFSET  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd4;

    // Configuration reset values.
    localparam logic [GAIN_W-1:0] GAIN_RESET    = 2'd1;
    localparam logic [HALF_W-1:0] HALF_RESET    = 8'd1;
    localparam logic [TMO_W-1:0]  TIMEOUT_RESET = 24'd500000;

    // Pin sequence modes.
    typedef enum logic [5:0] {
        M_IDLE       = 6'b000001,
        M_INIT_WAIT  = 6'b000010,
        M_INIT_CLK   = 6'b000100,
        M_READ_WAIT  = 6'b001000,
        M_READ_CLK   = 6'b010000,
        M_POWER_DOWN = 6'b100000
    } mode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic step;
        logic div_start;
        logic div_step;
        logic div_finish;
        logic load_out;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic read_done;
    } dp_status_t;

endpackage

// ===== design/lcasr_ctrl.sv =====
// Controller for the load-cell converter serial reader: beat handshakes,
// divider sequencing and output register valid. Depends on lcasr_pkg.
module lcasr_ctrl
    import lcasr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_DIV  = 5'b00100,
        S_FIX  = 5'b01000,
        S_PUSH = 5'b10000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg & out_stall;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.step   = 1'b1;
                    state_next = status.read_done ? S_PREP : S_PUSH;
                end
            end
            S_PREP:
            begin
                cmd.div_start = 1'b1;
                div_cnt_next  = DIV_CNT_W'(SUM_W - 1);
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == '0)
                begin
                    state_next = S_FIX;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
            end
            S_FIX:
            begin
                cmd.div_finish = 1'b1;
                state_next     = S_PUSH;
            end
            S_PUSH:
            begin
                // The output register takes the beat once it is empty or being drained.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/lcasr_dp.sv =====
// Datapath for the load-cell converter serial reader: configuration registers,
// per-tick pin sequencer state, sample correction, sum, serial divider and
// output registers. Depends on lcasr_pkg.
module lcasr_dp
    import lcasr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic [OP_W-1:0]          operation,
    input  logic                     dout_level,
    input  logic [CNT_W-1:0]         average_count,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    output logic                     sck_level,
    output logic                     busy_res,
    output logic                     result_valid,
    output logic signed [DATA_W-1:0] result,
    output logic                     timed_out
);

    // Configuration registers.
    logic [GAIN_W-1:0]   gain_pulses_reg;
    logic [RAW_W-1:0]    raw_offset_reg;
    logic [DATA_W-1:0]   zero_offset_reg;
    logic [HALF_W-1:0]   half_period_reg;
    logic [TMO_W-1:0]    timeout_reg;

    // Sequencer state.
    mode_t               mode_reg;
    mode_t               mode_next;
    logic                clock_reg;
    logic                clock_next;
    logic [HALF_W-1:0]   phase_reg;
    logic [HALF_W-1:0]   phase_next;
    logic [PULSE_W-1:0]  pulse_reg;
    logic [PULSE_W-1:0]  pulse_next;
    logic [ADC_BITS-1:0] shift_reg;
    logic [ADC_BITS-1:0] shift_next;
    logic [CNT_W-1:0]    left_reg;
    logic [CNT_W-1:0]    left_next;
    logic [CNT_W-1:0]    divisor_reg;
    logic [CNT_W-1:0]    divisor_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [TMO_W-1:0]    wait_reg;
    logic [TMO_W-1:0]    wait_next;

    // Per-tick results.
    logic                step_sck;
    logic                step_tmo;
    logic                step_done;
    logic [HALF_W-1:0]   half_ticks;
    logic [CNT_W-1:0]    count_clamped;

    // Corrected sample of the finished shift register.
    logic [ADC_BITS-1:0] code_adj;
    logic [DATA_W-1:0]   code_ext;
    logic [DATA_W-1:0]   sample_val_reg;

    // Divider.
    logic [SUM_W-1:0]    dvd_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic                neg_reg;
    logic [CNT_W:0]      rem_trial;
    logic [CNT_W:0]      rem_diff;
    logic                rem_ge;

    // Staged and output beat.
    logic                stage_sck_reg;
    logic                stage_busy_reg;
    logic                stage_valid_reg;
    logic                stage_tmo_reg;
    logic [DATA_W-1:0]   stage_result_reg;
    logic                out_sck_reg;
    logic                out_busy_reg;
    logic                out_valid_reg;
    logic                out_tmo_reg;
    logic [DATA_W-1:0]   out_result_reg;

    assign half_ticks = (half_period_reg == '0) ? HALF_W'(1) : half_period_reg;

    always_comb
    begin
        count_clamped = average_count;
        if (count_clamped == '0)
        begin
            count_clamped = CNT_W'(1);
        end
        if (count_clamped > CNT_W'(MAX_AVERAGES))
        begin
            count_clamped = CNT_W'(MAX_AVERAGES);
        end
    end

    // The raw code settles at least one tick before it is summed, so its correction is
    // registered here rather than chained onto the sum adder.
    assign code_adj = shift_reg - raw_offset_reg[ADC_BITS-1:0];
    assign code_ext = {{(DATA_W - ADC_BITS){code_adj[ADC_BITS-1]}}, code_adj};

    always_ff @(posedge clk)
    begin
        sample_val_reg <= code_ext - zero_offset_reg;
    end

    // One tick of the pin sequencer.
    always_comb
    begin
        mode_next    = mode_reg;
        clock_next   = clock_reg;
        phase_next   = phase_reg;
        pulse_next   = pulse_reg;
        shift_next   = shift_reg;
        left_next    = left_reg;
        divisor_next = divisor_reg;
        sum_next     = sum_reg;
        wait_next    = wait_reg;
        step_tmo     = 1'b0;
        step_done    = 1'b0;

        if (mode_reg == M_IDLE)
        begin
            unique case (operation)
                OP_TICK:
                begin
                    mode_next = M_IDLE;
                end
                OP_INIT:
                begin
                    clock_next = 1'b0;
                    wait_next  = '0;
                    mode_next  = M_INIT_WAIT;
                end
                OP_READ:
                begin
                    left_next    = count_clamped;
                    divisor_next = count_clamped;
                    sum_next     = '0;
                    clock_next   = 1'b0;
                    wait_next    = '0;
                    mode_next    = M_READ_WAIT;
                end
                OP_POWER_DOWN:
                begin
                    clock_next = 1'b1;
                    phase_next = HALF_W'(POWER_DOWN_TICKS);
                    mode_next  = M_POWER_DOWN;
                end
            endcase
        end

        step_sck = clock_next;

        unique case (mode_next)
            M_INIT_WAIT, M_READ_WAIT:
            begin
                if (!dout_level)
                begin
                    mode_next  = (mode_next == M_INIT_WAIT) ? M_INIT_CLK : M_READ_CLK;
                    clock_next = 1'b1;
                    phase_next = half_ticks;
                    pulse_next = '0;
                    shift_next = '0;
                end
                else if (wait_next >= timeout_reg)
                begin
                    step_tmo  = 1'b1;
                    mode_next = M_IDLE;
                end
                else
                begin
                    wait_next = wait_next + 1'b1;
                end
            end
            M_INIT_CLK, M_READ_CLK:
            begin
                // In a read, data bits are taken on the last tick of the high half of each data pulse.
                if (clock_next && (phase_next <= HALF_W'(1)) && (mode_next == M_READ_CLK)
                    && (pulse_next < PULSE_W'(ADC_BITS)))
                begin
                    shift_next = {shift_next[ADC_BITS-2:0], dout_level};
                end
                if (phase_next > HALF_W'(1))
                begin
                    phase_next = phase_next - 1'b1;
                end
                else if (clock_next)
                begin
                    clock_next = 1'b0;
                    phase_next = half_ticks;
                end
                else
                begin
                    pulse_next = pulse_next + 1'b1;
                    if (pulse_next < (PULSE_W'(ADC_BITS) + PULSE_W'(gain_pulses_reg)))
                    begin
                        clock_next = 1'b1;
                        phase_next = half_ticks;
                    end
                    else if (mode_next == M_INIT_CLK)
                    begin
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        sum_next  = sum_next + {{(SUM_W - DATA_W){sample_val_reg[DATA_W-1]}},
                                                sample_val_reg};
                        left_next = left_next - 1'b1;
                        if (left_next == '0)
                        begin
                            step_done = 1'b1;
                            mode_next = M_IDLE;
                        end
                        else
                        begin
                            wait_next = '0;
                            mode_next = M_READ_WAIT;
                        end
                    end
                end
            end
            M_POWER_DOWN:
            begin
                if (phase_next > HALF_W'(1))
                begin
                    phase_next = phase_next - 1'b1;
                end
                else
                begin
                    mode_next = M_IDLE;
                end
            end
            default:
            begin
                mode_next = M_IDLE;
            end
        endcase
    end

    assign status.read_done = step_done;

    // Restoring divider on the magnitude of the sum, one quotient bit a cycle.
    assign rem_trial = {rem_reg, dvd_reg[SUM_W-1]};
    assign rem_ge    = (rem_trial >= {1'b0, divisor_reg});
    assign rem_diff  = rem_trial - {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_pulses_reg <= GAIN_RESET;
            raw_offset_reg  <= '0;
            zero_offset_reg <= '0;
            half_period_reg <= HALF_RESET;
            timeout_reg     <= TIMEOUT_RESET;
            mode_reg        <= M_IDLE;
            clock_reg       <= 1'b0;
            phase_reg       <= '0;
            pulse_reg       <= '0;
            shift_reg       <= '0;
            left_reg        <= '0;
            divisor_reg     <= CNT_W'(1);
            sum_reg         <= '0;
            wait_reg        <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_GAIN_PULSES: gain_pulses_reg <= cfg_data[GAIN_W-1:0];
                    REG_RAW_OFFSET:  raw_offset_reg  <= cfg_data[RAW_W-1:0];
                    REG_ZERO_OFFSET: zero_offset_reg <= cfg_data[DATA_W-1:0];
                    REG_HALF_PERIOD: half_period_reg <= cfg_data[HALF_W-1:0];
                    REG_TIMEOUT:     timeout_reg     <= cfg_data[TMO_W-1:0];
                    default:         ;
                endcase
            end
            if (cmd.step)
            begin
                mode_reg    <= mode_next;
                clock_reg   <= clock_next;
                phase_reg   <= phase_next;
                pulse_reg   <= pulse_next;
                shift_reg   <= shift_next;
                left_reg    <= left_next;
                divisor_reg <= divisor_next;
                sum_reg     <= sum_next;
                wait_reg    <= wait_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            stage_sck_reg    <= step_sck;
            stage_busy_reg   <= (mode_next != M_IDLE);
            stage_valid_reg  <= step_done;
            stage_tmo_reg    <= step_tmo;
            stage_result_reg <= '0;
        end
        if (cmd.div_start)
        begin
            neg_reg <= sum_reg[SUM_W-1];
            dvd_reg <= sum_reg[SUM_W-1] ? (-sum_reg) : sum_reg;
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[SUM_W-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_diff[CNT_W-1:0] : rem_trial[CNT_W-1:0];
        end
        if (cmd.div_finish)
        begin
            stage_result_reg <= neg_reg ? (-dvd_reg[DATA_W-1:0]) : dvd_reg[DATA_W-1:0];
        end
        if (cmd.load_out)
        begin
            out_sck_reg    <= stage_sck_reg;
            out_busy_reg   <= stage_busy_reg;
            out_valid_reg  <= stage_valid_reg;
            out_tmo_reg    <= stage_tmo_reg;
            out_result_reg <= stage_result_reg;
        end
    end

    assign sck_level    = out_sck_reg;
    assign busy_res     = out_busy_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_result_reg;
    assign timed_out    = out_tmo_reg;

endmodule

// ===== design/load_cell_adc_serial_reader_core.sv =====
// Top level of the load-cell converter serial reader.
// Joins lcasr_ctrl and lcasr_dp. Depends on lcasr_pkg.
//
// Each input beat is one pin tick: the command code, the sampled data pin
// level and the averaging count. Each accepted beat gives exactly one output
// beat with the clock pin level for that tick, the busy flag, and the
// result_valid, result and timed_out fields of the tick.
// The configuration port writes one register per cycle on cfg_write and must be
// used only while the block holds no pending tick; the block does not enforce this.
// An ordinary tick passes from acceptance through the staging register into
// the output register. The tick that completes a read average first takes the
// magnitude of the sum, then runs the one-bit-per-cycle divider and restores
// the sign before it loads the output register.
// One tick is in work at a time; in_stall is high after acceptance until the
// tick's beat has moved into the output register.
// While the receiver stalls, the output beat holds and a finished tick waits
// in the staging register, so at most one more tick is taken meanwhile.
// Reset clears the configuration to its defaults, the sequencer to idle with
// its clock state low, and the output to empty.
module load_cell_adc_serial_reader_core
    import lcasr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [OP_W-1:0]          operation,
    input  logic                     dout_level,
    input  logic [CNT_W-1:0]         average_count,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     sck_level,
    output logic                     busy_res,
    output logic                     result_valid,
    output logic signed [DATA_W-1:0] result,
    output logic                     timed_out
);

    dp_cmd_t    cmd;
    dp_status_t status;

    lcasr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lcasr_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .operation     (operation),
        .dout_level    (dout_level),
        .average_count (average_count),
        .cmd           (cmd),
        .status        (status),
        .sck_level     (sck_level),
        .busy_res      (busy_res),
        .result_valid  (result_valid),
        .result        (result),
        .timed_out     (timed_out)
    );

endmodule

// ===== design/lcasr_checker.sv =====
// Port-level checks for the load-cell converter serial reader, bound to the
// top level. Depends on lcasr_pkg.
module lcasr_checker
    import lcasr_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic                     busy_res,
    input logic                     result_valid,
    input logic signed [DATA_W-1:0] result,
    input logic                     timed_out
);

    // A stalled output beat keeps its result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result))
    else $error("stalled output beat changed");

    // A tick cannot both complete a read and time out.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(result_valid && timed_out))
    else $error("result and timeout on the same tick");

    // Without a completed read the result field reads zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !result_valid |-> result == '0)
    else $error("nonzero result without result_valid");

    // A completed read or a timeout ends the sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_valid || timed_out) |-> !busy_res)
    else $error("sequence still busy after it ended");

endmodule

bind load_cell_adc_serial_reader_core lcasr_checker u_lcasr_checker (.*);
